@@ hw/rtl/tdbm_pkg.sv @@
// ----------------------------------------------------------------------------
// tdbm_pkg: shared types and constants for the thermal delta monitor
// Field widths, register indexes, reset values and conversion constants.
// ----------------------------------------------------------------------------
package tdbm_pkg;

  // Field widths
  localparam int RAW_W    = 16;
  localparam int LOCAL_W  = 19;
  localparam int REMOTE_W = 20;
  localparam int DELTA_W  = 19;
  localparam int BOUND_W  = 20;
  localparam int OFFSET_W = 17;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  // Extended range subtracts 64 degrees, i.e. 64*256 raw counts
  localparam int EXT_SHIFT_RAW = 64 * 256;

  // (t*625 + 80) / 160 equals (t*125 + 16) / 32 exactly: both sides carry a
  // common factor of 5, so the divide collapses to a shift.
  localparam int CONV_SCALE = 625 / 5;
  localparam int CONV_ROUND = 80 / 5;
  localparam int CONV_SHIFT = 5;           // 160 / 5 = 32 = 2**5
  localparam int PROD_W     = 25;          // holds t*125+16 for t in 17 bits

  localparam logic [DELTA_W-1:0]  DEFAULT_DELTA = DELTA_W'(4000);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELTA_THRESHOLD   = 2'd0,
    REG_REMOTE_LOW_BOUND  = 2'd1,
    REG_REMOTE_HIGH_BOUND = 2'd2,
    REG_RMT_OFFSET        = 2'd3
  } cfg_index_t;

  // Live configuration
  typedef struct packed {
    logic        [DELTA_W-1:0]  delta_threshold;
    logic signed [BOUND_W-1:0]  remote_low_bound;
    logic signed [BOUND_W-1:0]  remote_high_bound;
    logic signed [OFFSET_W-1:0] rmt_offset;
  } cfg_regs_t;

  // Per-item report decision
  typedef struct packed {
    logic local_hit;
    logic remote_hit;
    logic remote_rise;
  } decision_t;

endpackage

@@ hw/rtl/tdbm_conv.sv @@
// ----------------------------------------------------------------------------
// tdbm_conv: raw sensor word to millidegrees
// Applies the extended-range shift, scales by 125/32 with rounding term and
// truncates toward zero.
// ----------------------------------------------------------------------------
module tdbm_conv (
  input  logic [tdbm_pkg::RAW_W-1:0]          raw,
  input  logic                                extended_range,
  output logic signed [tdbm_pkg::LOCAL_W-1:0] temp
);
  import tdbm_pkg::*;

  logic signed [RAW_W:0]    shifted;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] quot;

  // Remove the extended-range offset
  assign shifted = $signed({1'b0, raw})
                 - (extended_range ? (RAW_W+1)'(EXT_SHIFT_RAW) : '0);

  // Scale and add the rounding term
  assign prod = PROD_W'(shifted) * PROD_W'(CONV_SCALE) + PROD_W'(CONV_ROUND);

  // Truncate toward zero: negative values get 2**shift-1 added first
  assign biased = prod[PROD_W-1] ? prod + PROD_W'((1 << CONV_SHIFT) - 1) : prod;
  assign quot   = biased >>> CONV_SHIFT;
  assign temp   = quot[LOCAL_W-1:0];

endmodule

@@ hw/rtl/tdbm_cfg.sv @@
// ----------------------------------------------------------------------------
// tdbm_cfg: configuration register file
// Four registers written through a valid/ready port that is always ready.
// ----------------------------------------------------------------------------
module tdbm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdbm_pkg::CFG_W-1:0]        cfg_data,
  output tdbm_pkg::cfg_regs_t               regs
);
  import tdbm_pkg::*;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.delta_threshold   <= DEFAULT_DELTA;
      regs.remote_low_bound  <= '0;
      regs.remote_high_bound <= '0;
      regs.rmt_offset        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        REG_DELTA_THRESHOLD:   regs.delta_threshold   <= cfg_data[DELTA_W-1:0];
        REG_REMOTE_LOW_BOUND:  regs.remote_low_bound  <= $signed(cfg_data[BOUND_W-1:0]);
        REG_REMOTE_HIGH_BOUND: regs.remote_high_bound <= $signed(cfg_data[BOUND_W-1:0]);
        REG_RMT_OFFSET:        regs.rmt_offset        <= $signed(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/tdbm_eval.sv @@
// ----------------------------------------------------------------------------
// tdbm_eval: report decisions
// Local delta test against the last local report and remote boundary
// crossing tests against the last remote report.
// ----------------------------------------------------------------------------
module tdbm_eval (
  input  logic signed [tdbm_pkg::LOCAL_W-1:0]  cur_local,
  input  logic signed [tdbm_pkg::REMOTE_W-1:0] cur_remote,
  input  logic signed [tdbm_pkg::LOCAL_W-1:0]  last_local,
  input  logic signed [tdbm_pkg::REMOTE_W-1:0] last_remote,
  input  logic                                 local_read_ok,
  input  logic                                 remote_read_ok,
  input  tdbm_pkg::cfg_regs_t                  regs,
  output tdbm_pkg::decision_t                  dec
);
  import tdbm_pkg::*;

  logic signed [LOCAL_W:0] diff;
  logic        [LOCAL_W:0] mag;
  logic [DELTA_W-1:0]      th;
  logic                    rise;
  logic                    fall;

  // Local: |cur - last| >= delta, zero delta means the default
  assign diff = (LOCAL_W+1)'(cur_local) - (LOCAL_W+1)'(last_local);
  assign mag  = diff[LOCAL_W] ? (LOCAL_W+1)'(-diff) : (LOCAL_W+1)'(diff);
  assign th   = (regs.delta_threshold == '0) ? DEFAULT_DELTA : regs.delta_threshold;

  // Remote: rising crossing wins over falling
  assign rise = (last_remote < regs.remote_high_bound)
             && (cur_remote >= regs.remote_high_bound);
  assign fall = (last_remote >= regs.remote_low_bound)
             && (cur_remote < regs.remote_low_bound);

  assign dec.local_hit   = local_read_ok && (mag >= {1'b0, th});
  assign dec.remote_hit  = remote_read_ok && (rise || fall);
  assign dec.remote_rise = remote_read_ok && rise;

endmodule

@@ hw/rtl/thermal_delta_and_boundary_monitor.sv @@
// ----------------------------------------------------------------------------
// thermal_delta_and_boundary_monitor: local delta and remote boundary monitor
// Converts polled sensor words to millidegrees and flags local changes and
// remote boundary crossings.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_ready    | local_raw, remote_raw, extended_range,
//          |                        | local_read_ok, remote_read_ok
//  out     | out_valid / out_ready  | local_changed, local_mdeg,
//          |                        | remote_changed, remote_mdeg, remote_rising
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One beat per cycle sustained while out_ready stays high; an accepted input
// beat passes through the input register, then the result register.
// Conversion and decisions are combinational between the two registers; the
// last-report state updates when a beat moves into the result register.
// Stalls on out_ready hold the result register and back up into the input
// register; in_ready drops only when both are full and out_ready is low.
// Synchronous reset clears valids and last reports and restores configuration defaults.
// ----------------------------------------------------------------------------
module thermal_delta_and_boundary_monitor (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tdbm_pkg::RAW_W-1:0]            local_raw,
  input  logic [tdbm_pkg::RAW_W-1:0]            remote_raw,
  input  logic                                  extended_range,
  input  logic                                  local_read_ok,
  input  logic                                  remote_read_ok,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  local_changed,
  output logic signed [tdbm_pkg::LOCAL_W-1:0]   local_mdeg,
  output logic                                  remote_changed,
  output logic signed [tdbm_pkg::REMOTE_W-1:0]  remote_mdeg,
  output logic                                  remote_rising,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdbm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tdbm_pkg::CFG_W-1:0]            cfg_data
);
  import tdbm_pkg::*;

  cfg_regs_t regs;
  decision_t dec;

  logic                       s1_valid;
  logic [RAW_W-1:0]           s1_local_raw;
  logic [RAW_W-1:0]           s1_remote_raw;
  logic                       s1_ext;
  logic                       s1_lok;
  logic                       s1_rok;
  logic                       advance;

  logic signed [LOCAL_W-1:0]  conv_local;
  logic signed [LOCAL_W-1:0]  conv_remote;
  logic signed [REMOTE_W-1:0] cur_remote;
  logic signed [LOCAL_W-1:0]  last_local;
  logic signed [REMOTE_W-1:0] last_remote;

  // Configuration registers
  tdbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Handshake: input stage moves when the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_local_raw  <= local_raw;
      s1_remote_raw <= remote_raw;
      s1_ext        <= extended_range;
      s1_lok        <= local_read_ok;
      s1_rok        <= remote_read_ok;
    end
  end

  // Conversions
  tdbm_conv u_conv_local (
    .raw            (s1_local_raw),
    .extended_range (s1_ext),
    .temp           (conv_local)
  );

  tdbm_conv u_conv_remote (
    .raw            (s1_remote_raw),
    .extended_range (s1_ext),
    .temp           (conv_remote)
  );

  assign cur_remote = REMOTE_W'(conv_remote) + REMOTE_W'(regs.rmt_offset);

  // Decisions
  tdbm_eval u_eval (
    .cur_local      (conv_local),
    .cur_remote     (cur_remote),
    .last_local     (last_local),
    .last_remote    (last_remote),
    .local_read_ok  (s1_lok),
    .remote_read_ok (s1_rok),
    .regs           (regs),
    .dec            (dec)
  );

  // Last-report state, updated only on a report
  always_ff @(posedge clk) begin
    if (rst) begin
      last_local  <= '0;
      last_remote <= '0;
    end else if (advance) begin
      if (dec.local_hit)  last_local  <= conv_local;
      if (dec.remote_hit) last_remote <= cur_remote;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      local_changed  <= dec.local_hit;
      local_mdeg     <= dec.local_hit ? conv_local : '0;
      remote_changed <= dec.remote_hit;
      remote_mdeg    <= dec.remote_hit ? cur_remote : '0;
      remote_rising  <= dec.remote_rise;
    end
  end

  // Checks
  a_rise_needs_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && remote_rising |-> remote_changed)
    else $error("rising flag without remote report");

  a_local_zero_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !local_changed |-> local_mdeg == '0)
    else $error("local temp nonzero without report");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("beat lost between stages");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_local_raw)
      && $stable(s1_remote_raw))
    else $error("input stage changed while stalled");

endmodule

@@ tb/tdbm_report_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdbm_report_checker: report predictor and comparator for the thermal monitor
// Watches the poll, result and register channels, keeps its own copy of the
// thresholds and last reports, predicts one report per accepted poll and
// compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tdbm_report_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  // poll channel
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [tdbm_pkg::RAW_W-1:0]           local_raw,
  input  logic [tdbm_pkg::RAW_W-1:0]           remote_raw,
  input  logic                                 extended_range,
  input  logic                                 local_read_ok,
  input  logic                                 remote_read_ok,
  // result channel
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 local_changed,
  input  logic signed [tdbm_pkg::LOCAL_W-1:0]  local_mdeg,
  input  logic                                 remote_changed,
  input  logic signed [tdbm_pkg::REMOTE_W-1:0] remote_mdeg,
  input  logic                                 remote_rising,
  // register channel
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [tdbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdbm_pkg::CFG_W-1:0]           cfg_data,
  // status to the testbench top
  output int                                   fail_count,
  output int                                   reports_due
);

  // raw counts to millidegrees: (t * 625 + 80) / 160
  localparam longint MDEG_MUL = 625;
  localparam longint MDEG_ADD = 80;
  localparam longint MDEG_DIV = 160;
  localparam int     MAX_SHOWN = 10;

  typedef struct packed {
    logic                                 local_changed;
    logic signed [tdbm_pkg::LOCAL_W-1:0]  local_mdeg;
    logic                                 remote_changed;
    logic signed [tdbm_pkg::REMOTE_W-1:0] remote_mdeg;
    logic                                 remote_rising;
  } report_t;

  // mirrored registers and last reported values
  longint  delta_th;
  longint  low_bound;
  longint  high_bound;
  longint  remote_ofs;
  longint  last_local;
  longint  last_remote;

  report_t due_reports[$];
  int      fail_total = 0;

  function automatic longint to_millideg(input logic [tdbm_pkg::RAW_W-1:0] raw,
                                         input logic ext);
    longint t;
    t = longint'(raw);
    if (ext) t = t - tdbm_pkg::EXT_SHIFT_RAW;
    // longint divide truncates toward zero
    return (t * MDEG_MUL + MDEG_ADD) / MDEG_DIV;
  endfunction

  // Predict the report for one poll and advance the last-report state
  function automatic report_t predict_report(input logic [tdbm_pkg::RAW_W-1:0] lraw,
                                             input logic [tdbm_pkg::RAW_W-1:0] rraw,
                                             input logic ext,
                                             input logic lok,
                                             input logic rok);
    report_t r;
    longint  cur;
    longint  diff;
    longint  th;
    r = '0;
    // local: delta against last reported value, zero delta means default
    if (lok) begin
      cur  = to_millideg(lraw, ext);
      diff = cur - last_local;
      if (diff < 0) diff = -diff;
      th = (delta_th == 0) ? longint'(tdbm_pkg::DEFAULT_DELTA) : delta_th;
      if (diff >= th) begin
        last_local      = cur;
        r.local_changed = 1'b1;
        r.local_mdeg    = cur[tdbm_pkg::LOCAL_W-1:0];
      end
    end
    // remote: rising crossing wins over falling crossing
    if (rok) begin
      cur = to_millideg(rraw, ext) + remote_ofs;
      if (last_remote < high_bound && cur >= high_bound) begin
        r.remote_changed = 1'b1;
        r.remote_rising  = 1'b1;
      end else if (last_remote >= low_bound && cur < low_bound) begin
        r.remote_changed = 1'b1;
      end
      if (r.remote_changed) begin
        last_remote   = cur;
        r.remote_mdeg = cur[tdbm_pkg::REMOTE_W-1:0];
      end
    end
    return r;
  endfunction

  // Channel monitor: compare result beats, mirror register writes, predict
  always @(posedge clk) begin : monitor
    report_t got;
    report_t want;
    if (rst) begin
      delta_th    = longint'(tdbm_pkg::DEFAULT_DELTA);
      low_bound   = 0;
      high_bound  = 0;
      remote_ofs  = 0;
      last_local  = 0;
      last_remote = 0;
      due_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.local_changed  = local_changed;
        got.local_mdeg     = local_mdeg;
        got.remote_changed = remote_changed;
        got.remote_mdeg    = remote_mdeg;
        got.remote_rising  = remote_rising;
        if (due_reports.size() == 0) begin
          fail_total++;
          if (fail_total <= MAX_SHOWN)
            $display({"%0t: result beat with no report due: ",
                      "lchg=%0d ltemp=%0d rchg=%0d rtemp=%0d rise=%0d"},
                     $time, got.local_changed, got.local_mdeg, got.remote_changed,
                     got.remote_mdeg, got.remote_rising);
        end else begin
          want = due_reports.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= MAX_SHOWN)
              $display({"%0t: report mismatch: expected lchg=%0d ltemp=%0d rchg=%0d ",
                        "rtemp=%0d rise=%0d, got lchg=%0d ltemp=%0d rchg=%0d ",
                        "rtemp=%0d rise=%0d"},
                       $time, want.local_changed, want.local_mdeg, want.remote_changed,
                       want.remote_mdeg, want.remote_rising, got.local_changed,
                       got.local_mdeg, got.remote_changed, got.remote_mdeg,
                       got.remote_rising);
          end
        end
      end

      // register writes; upper data bits beyond a field are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdbm_pkg::REG_DELTA_THRESHOLD:
            delta_th = longint'(cfg_data[tdbm_pkg::DELTA_W-1:0]);
          tdbm_pkg::REG_REMOTE_LOW_BOUND:
            low_bound = longint'($signed(cfg_data[tdbm_pkg::BOUND_W-1:0]));
          tdbm_pkg::REG_REMOTE_HIGH_BOUND:
            high_bound = longint'($signed(cfg_data[tdbm_pkg::BOUND_W-1:0]));
          tdbm_pkg::REG_RMT_OFFSET:
            remote_ofs = longint'($signed(cfg_data[tdbm_pkg::OFFSET_W-1:0]));
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        due_reports.push_back(predict_report(local_raw, remote_raw, extended_range,
                                             local_read_ok, remote_read_ok));
    end
    fail_count  <= fail_total;
    reports_due <= due_reports.size();
  end

endmodule

@@ tb/thermal_delta_and_boundary_monitor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_delta_and_boundary_monitor_tb: poll stimulus and verdict
// Drives directed and random sensor polls through several register settings
// with random idling on both sides and one long result hold-off; the
// report checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module thermal_delta_and_boundary_monitor_tb;

  localparam int LIMIT          = 400000;
  localparam int NUM_PHASES     = 14;
  localparam int PHASE_ITEMS    = 140;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_GAP        = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int EXT_RAW        = 16384;
  localparam int RAW_MAX        = 65535;

  logic clk;
  logic rst;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [tdbm_pkg::RAW_W-1:0]           local_raw;
  logic [tdbm_pkg::RAW_W-1:0]           remote_raw;
  logic                                 extended_range;
  logic                                 local_read_ok;
  logic                                 remote_read_ok;
  logic                                 out_valid;
  logic                                 out_ready;
  logic                                 local_changed;
  logic signed [tdbm_pkg::LOCAL_W-1:0]  local_mdeg;
  logic                                 remote_changed;
  logic signed [tdbm_pkg::REMOTE_W-1:0] remote_mdeg;
  logic                                 remote_rising;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [tdbm_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [tdbm_pkg::CFG_W-1:0]           cfg_data;

  int fail_count;
  int reports_due;

  // idling controls shared with the result sink
  bit snd_quiet = 1'b0;
  bit rcv_quiet = 1'b0;
  int hold_seq  = 0;

  thermal_delta_and_boundary_monitor i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .local_raw      (local_raw),
    .remote_raw     (remote_raw),
    .extended_range (extended_range),
    .local_read_ok  (local_read_ok),
    .remote_read_ok (remote_read_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .local_changed  (local_changed),
    .local_mdeg     (local_mdeg),
    .remote_changed (remote_changed),
    .remote_mdeg    (remote_mdeg),
    .remote_rising  (remote_rising),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  tdbm_report_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .local_raw      (local_raw),
    .remote_raw     (remote_raw),
    .extended_range (extended_range),
    .local_read_ok  (local_read_ok),
    .remote_read_ok (remote_read_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .local_changed  (local_changed),
    .local_mdeg     (local_mdeg),
    .remote_changed (remote_changed),
    .remote_mdeg    (remote_mdeg),
    .remote_rising  (remote_rising),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .reports_due    (reports_due)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("thermal_delta_and_boundary_monitor_tb: errors");
    $finish;
  end

  // Result sink: random stall before each beat, long hold-off on request
  initial begin : result_sink
    int stall;
    int hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, MAX_GAP);
      if (rcv_quiet) stall = 0;
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        stall     = stall + HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic logic [tdbm_pkg::RAW_W-1:0] clamp_raw(input int v);
    if (v < 0) return '0;
    if (v > RAW_MAX) return '1;
    return v[tdbm_pkg::RAW_W-1:0];
  endfunction

  // One poll beat; valid stays high afterward so beats can go back to back
  task automatic send_poll(input logic [tdbm_pkg::RAW_W-1:0] lraw,
                           input logic [tdbm_pkg::RAW_W-1:0] rraw,
                           input logic ext, input logic lok, input logic rok);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    if (snd_quiet) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    local_raw      <= lraw;
    remote_raw     <= rraw;
    extended_range <= ext;
    local_read_ok  <= lok;
    remote_read_ok <= rok;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Drop valid, wait for every due report, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; junk above narrow fields must be dropped
  task automatic program_regs(input int delta, input int lo, input int hi, input int ofs);
    tdbm_pkg::cfg_index_t       reg_order[4];
    logic [tdbm_pkg::CFG_W-1:0] wdata[4];
    int                         k;
    reg_order[0] = tdbm_pkg::REG_DELTA_THRESHOLD;
    reg_order[1] = tdbm_pkg::REG_REMOTE_LOW_BOUND;
    reg_order[2] = tdbm_pkg::REG_REMOTE_HIGH_BOUND;
    reg_order[3] = tdbm_pkg::REG_RMT_OFFSET;
    wdata[0] = {1'($urandom_range(0, 1)), delta[tdbm_pkg::DELTA_W-1:0]};
    wdata[1] = lo[tdbm_pkg::BOUND_W-1:0];
    wdata[2] = hi[tdbm_pkg::BOUND_W-1:0];
    wdata[3] = {3'($urandom_range(0, 7)), ofs[tdbm_pkg::OFFSET_W-1:0]};
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[k];
      cfg_data  <= wdata[k];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    cfg_valid <= 1'b0;
  endtask

  // Main stimulus and verdict
  initial begin : stimulus
    int                         ph;
    int                         n;
    int                         delta;
    int                         lo;
    int                         hi;
    int                         ofs;
    int                         temp;
    int                         raw_i;
    logic [tdbm_pkg::RAW_W-1:0] prev_local;
    logic [tdbm_pkg::RAW_W-1:0] lraw;
    logic [tdbm_pkg::RAW_W-1:0] rraw;
    logic                       ext;

    rst            <= 1'b1;
    in_valid       <= 1'b0;
    local_raw      <= '0;
    remote_raw     <= '0;
    extended_range <= 1'b0;
    local_read_ok  <= 1'b0;
    remote_read_ok <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= tdbm_pkg::REG_DELTA_THRESHOLD;
    cfg_data       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed polls under reset settings: range ends, failed reads,
    // crossings both ways and delta exactly met
    send_poll(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
    send_poll(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    send_poll(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_poll(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_poll(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_poll(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_poll(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_poll(16'h4000, 16'h4000, 1'b1, 1'b1, 1'b1);
    send_poll(16'h3FFF, 16'h3FFF, 1'b1, 1'b1, 1'b1);
    send_poll(16'h0001, 16'h0001, 1'b0, 1'b1, 1'b1);
    send_poll(16'h0400, 16'h0FA0, 1'b0, 1'b1, 1'b1);
    send_poll(16'h03FF, 16'h0000, 1'b0, 1'b1, 1'b1);
    send_poll(16'h8000, 16'h00FF, 1'b0, 1'b1, 1'b1);
    send_poll(16'h7FFF, 16'hFF00, 1'b1, 1'b1, 1'b1);
    send_poll(16'hAAAA, 16'h5555, 1'b0, 1'b1, 1'b1);
    send_poll(16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b1);
    send_poll(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
    send_poll(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);

    prev_local = 16'h4000;
    ext        = 1'b0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // settings for this phase: fixed extremes first, then random
      case (ph)
        0: begin delta = 0;       lo = -128000; hi = 320000;  ofs = 0;      end
        1: begin delta = 1;       lo = 320000;  hi = -128000; ofs = -64000; end
        2: begin delta = 320000;  lo = -128000; hi = -128000; ofs = 64000;  end
        3: begin delta = 524287;  lo = -524288; hi = 524287;  ofs = -65536; end
        default: begin
          case ($urandom_range(0, 3))
            0: delta = $urandom_range(1, 2000);
            1: delta = $urandom_range(2000, 20000);
            2: delta = $urandom_range(20000, 320000);
            default: delta = int'(tdbm_pkg::DEFAULT_DELTA);
          endcase
          lo = int'($urandom_range(0, 448000)) - 128000;
          if ($urandom_range(0, 1))
            hi = lo + int'($urandom_range(0, 30000));
          else
            hi = int'($urandom_range(0, 448000)) - 128000;
          ofs = int'($urandom_range(0, 128000)) - 64000;
        end
      endcase
      wait_idle();
      program_regs(delta, lo, hi, ofs);

      snd_quiet = (ph == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      rcv_quiet = (ph != PRESSURE_PHASE) && ($urandom_range(0, 3) == 0);
      if (ph == PRESSURE_PHASE) hold_seq++;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) ext = ~ext;
        // local: half the time a walk around the last value, else anywhere
        if ($urandom_range(0, 1))
          lraw = clamp_raw(int'(prev_local) + int'($urandom_range(0, 4096)) - 2048);
        else
          lraw = 16'($urandom_range(0, RAW_MAX));
        prev_local = lraw;
        // remote: mostly just either side of a boundary, rest anywhere
        case ($urandom_range(0, 4))
          0, 1: temp = hi - ofs + int'($urandom_range(0, 4000)) - 2000;
          2, 3: temp = lo - ofs + int'($urandom_range(0, 4000)) - 2000;
          default: temp = int'($urandom_range(0, 384000)) - 64000;
        endcase
        raw_i = (temp * 32) / 125 + (ext ? EXT_RAW : 0);
        rraw  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, RAW_MAX))
                                            : clamp_raw(raw_i);
        send_poll(lraw, rraw, ext, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      end
    end

    wait_idle();
    if (fail_count == 0 && reports_due == 0)
      $display("thermal_delta_and_boundary_monitor_tb: clean");
    else
      $display("thermal_delta_and_boundary_monitor_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tdbm_pkg.sv
hw/rtl/tdbm_conv.sv
hw/rtl/tdbm_cfg.sv
hw/rtl/tdbm_eval.sv
hw/rtl/thermal_delta_and_boundary_monitor.sv
tb/tdbm_report_checker.sv
tb/thermal_delta_and_boundary_monitor_tb.sv
